// File: src/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// Used by u8d_scan and utf8_stream_decoder; no dependencies.
package u8d_pkg;

    localparam int CP_W     = 21;
    localparam int USED_W   = 3;
    localparam int MAX_RES  = 4;
    localparam int HELD_N   = 3;
    localparam int GRP_DEPTH = 2;
    localparam int GRP_PTR_W = (GRP_DEPTH > 1) ? $clog2(GRP_DEPTH) : 1;
    localparam int GRP_CNT_W = $clog2(GRP_DEPTH + 1);

    localparam logic [7:0]       LEAD2_MIN  = 8'hC2;
    localparam logic [15:0]      MIN_CP3    = 16'h0800;
    localparam logic [15:0]      SURR_LO    = 16'hD800;
    localparam logic [15:0]      SURR_HI    = 16'hDFFF;
    localparam logic [CP_W-1:0]  MIN_CP4    = 21'h010000;
    localparam logic [CP_W-1:0]  MAX_CP     = 21'h10FFFF;

    localparam logic [USED_W-1:0] LEN_NONE = 3'd0;
    localparam logic [USED_W-1:0] LEN_1    = 3'd1;
    localparam logic [USED_W-1:0] LEN_2    = 3'd2;
    localparam logic [USED_W-1:0] LEN_3    = 3'd3;
    localparam logic [USED_W-1:0] LEN_4    = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0]   cp;
        logic [USED_W-1:0] used;
        logic              err;
    } u8d_res_t;

    typedef struct packed {
        logic     hold;
        u8d_res_t res;
    } u8d_lead_t;

    typedef struct packed {
        u8d_res_t [MAX_RES-1:0] res;
        logic [2:0]             nres;
        logic [8*HELD_N-1:0]    held;
        logic [1:0]             held_cnt;
    } u8d_step_t;

    typedef struct packed {
        u8d_res_t [MAX_RES-1:0] res;
        logic [2:0]             nres;
        logic                   eot;
    } u8d_grp_t;

endpackage

// File: src/u8d_scan.sv
// One decode step: held bytes plus the new byte scanned into up to four results.
// Depends on u8d_pkg.
module u8d_scan (
    input  logic [23:0]          held,
    input  logic [1:0]           held_cnt,
    input  logic [7:0]           text_byte,
    input  logic                 eot,
    output u8d_pkg::u8d_step_t   step
);

    function automatic u8d_pkg::u8d_lead_t eval_lead(
        input logic [31:0] b,
        input logic [2:0]  avail,
        input logic        end_txt
    );
        logic [7:0]  lead;
        logic [2:0]  n;
        logic        c1, c2, c3, ok;
        logic [15:0] v3;
        logic [20:0] v4;
        u8d_pkg::u8d_lead_t r;
        lead = b[7:0];
        c1 = (b[15:14] == 2'b10);
        c2 = (b[23:22] == 2'b10);
        c3 = (b[31:30] == 2'b10);
        v3 = {lead[3:0], b[13:8], b[21:16]};
        v4 = {lead[2:0], b[13:8], b[21:16], b[29:24]};
        if (lead[7] == 1'b0) begin
            n = u8d_pkg::LEN_1;
        end else if (lead[7:5] == 3'b110) begin
            n = u8d_pkg::LEN_2;
        end else if (lead[7:4] == 4'b1110) begin
            n = u8d_pkg::LEN_3;
        end else if (lead[7:3] == 5'b11110) begin
            n = u8d_pkg::LEN_4;
        end else begin
            n = u8d_pkg::LEN_NONE;
        end
        r.hold     = 1'b0;
        r.res.cp   = '0;
        r.res.used = u8d_pkg::LEN_1;
        r.res.err  = 1'b1;
        ok         = 1'b0;
        case (n)
            u8d_pkg::LEN_2: ok = c1 && (lead >= u8d_pkg::LEAD2_MIN);
            u8d_pkg::LEN_3: ok = c1 && c2 && (v3 >= u8d_pkg::MIN_CP3)
                              && !((v3 >= u8d_pkg::SURR_LO) && (v3 <= u8d_pkg::SURR_HI));
            u8d_pkg::LEN_4: ok = c1 && c2 && c3 && (v4 >= u8d_pkg::MIN_CP4)
                              && (v4 <= u8d_pkg::MAX_CP);
            default:        ok = 1'b0;
        endcase
        if (n == u8d_pkg::LEN_1) begin
            r.res.cp  = 21'(lead);
            r.res.err = 1'b0;
        end else if (n == u8d_pkg::LEN_NONE) begin
            r.res.err = 1'b1;
        end else if (avail < n) begin
            r.hold = !end_txt;
        end else if (ok) begin
            r.res.used = n;
            r.res.err  = 1'b0;
            case (n)
                u8d_pkg::LEN_2: r.res.cp = 21'({lead[4:0], b[13:8]});
                u8d_pkg::LEN_3: r.res.cp = 21'(v3);
                default:        r.res.cp = v4;
            endcase
        end
        return r;
    endfunction

    logic [31:0]                          win;
    logic [2:0]                           cnt;
    u8d_pkg::u8d_lead_t [3:0]             lr;
    logic [31:0]                          rest;
    logic [2:0]                           pos;
    logic                                 stop;
    u8d_pkg::u8d_lead_t                   cur;

    assign cnt = {1'b0, held_cnt} + 3'd1;

    always_comb begin
        win = '0;
        for (int k = 0; k < u8d_pkg::HELD_N; k++) begin
            if (2'(k) < held_cnt) begin
                win[8*k +: 8] = held[8*k +: 8];
            end
        end
        win[{held_cnt, 3'b000} +: 8] = text_byte;
    end

    for (genvar p = 0; p < 4; p++) begin : g_pos
        assign lr[p] = eval_lead(32'(win >> (8*p)), cnt - 3'(p), eot);
    end

    always_comb begin
        pos       = 3'd0;
        stop      = 1'b0;
        cur       = '0;
        step.res  = '0;
        step.nres = 3'd0;
        for (int i = 0; i < u8d_pkg::MAX_RES; i++) begin
            if (!stop && (pos < cnt)) begin
                cur = lr[pos[1:0]];
                if (cur.hold) begin
                    stop = 1'b1;
                end else begin
                    step.res[i] = cur.res;
                    step.nres   = step.nres + 3'd1;
                    pos         = pos + cur.res.used;
                end
            end
        end
        rest          = win >> {pos, 3'b000};
        step.held     = rest[23:0];
        step.held_cnt = 2'(cnt - pos);
    end

endmodule

// File: src/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: input register, decode step, result queue.
// Depends on u8d_pkg and u8d_scan.
//
//   channel | dir | tdata                                  | tuser                   | tlast
//   s_      | in  | [7:0] text_byte                        | -                       | end_of_text
//   m_      | out | [20:0] code_point, [23:21] bytes_used  | [0] is_error,[1] run_last | text_done
//
// One byte per cycle while s_tready is high; each byte is registered in the input register
// before it reaches the decode step. A byte yields 0..4 results, sent one per cycle while
// m_tready is high from a two-entry group queue; a byte with results waits while it is full.
// aresetn (sync, active low) empties the input register, the queue and the held bytes.
// A stalled m_ side fills the queue, then s_tready drops.
module utf8_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] bytes_used
    output logic [1:0]  m_tuser,   // [0] is_error, [1] run_last
    output logic        m_tlast
);

    logic                              in_valid_reg;
    logic [7:0]                        in_byte_reg;
    logic                              in_eot_reg;
    logic [23:0]                       held_reg;
    logic [1:0]                        held_cnt_reg;
    u8d_pkg::u8d_grp_t                 grp_reg [u8d_pkg::GRP_DEPTH];
    logic [u8d_pkg::GRP_PTR_W-1:0]     head_reg, tail_reg;
    logic [u8d_pkg::GRP_CNT_W-1:0]     grp_cnt_reg, grp_cnt_next;
    logic [1:0]                        idx_reg;

    u8d_pkg::u8d_step_t                step;
    u8d_pkg::u8d_grp_t                 cur_grp;
    u8d_pkg::u8d_res_t                 cur_res;
    logic                              adv, push, pop, s_acc, m_acc, run_last;

    u8d_scan u_scan (
        .held      (held_reg),
        .held_cnt  (held_cnt_reg),
        .text_byte (in_byte_reg),
        .eot       (in_eot_reg),
        .step      (step)
    );

    assign adv   = in_valid_reg
                   && ((grp_cnt_reg != u8d_pkg::GRP_CNT_W'(u8d_pkg::GRP_DEPTH))
                       || (step.nres == 3'd0));
    assign push  = adv && (step.nres != 3'd0);
    assign s_tready = !in_valid_reg || adv;
    assign s_acc = s_tvalid && s_tready;

    assign cur_grp  = grp_reg[head_reg];
    assign cur_res  = cur_grp.res[idx_reg];
    assign run_last = ({1'b0, idx_reg} == (cur_grp.nres - 3'd1));
    assign m_tvalid = (grp_cnt_reg != '0);
    assign m_tdata  = {cur_res.used, cur_res.cp};
    assign m_tuser  = {run_last, cur_res.err};
    assign m_tlast  = run_last && cur_grp.eot;
    assign m_acc    = m_tvalid && m_tready;
    assign pop      = m_acc && run_last;

    always_comb begin
        grp_cnt_next = grp_cnt_reg;
        if (push && !pop) begin
            grp_cnt_next = grp_cnt_reg + u8d_pkg::GRP_CNT_W'(1);
        end else if (pop && !push) begin
            grp_cnt_next = grp_cnt_reg - u8d_pkg::GRP_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            held_cnt_reg <= 2'd0;
            head_reg     <= '0;
            tail_reg     <= '0;
            grp_cnt_reg  <= '0;
            idx_reg      <= 2'd0;
        end else begin
            if (s_acc) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                held_cnt_reg <= step.held_cnt;
            end
            if (push) begin
                tail_reg <= (tail_reg == u8d_pkg::GRP_PTR_W'(u8d_pkg::GRP_DEPTH - 1))
                            ? '0 : tail_reg + u8d_pkg::GRP_PTR_W'(1);
            end
            if (pop) begin
                head_reg <= (head_reg == u8d_pkg::GRP_PTR_W'(u8d_pkg::GRP_DEPTH - 1))
                            ? '0 : head_reg + u8d_pkg::GRP_PTR_W'(1);
                idx_reg  <= 2'd0;
            end else if (m_acc) begin
                idx_reg  <= idx_reg + 2'd1;
            end
            grp_cnt_reg <= grp_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
        if (adv) begin
            held_reg <= step.held;
        end
        if (push) begin
            grp_reg[tail_reg].res  <= step.res;
            grp_reg[tail_reg].nres <= step.nres;
            grp_reg[tail_reg].eot  <= in_eot_reg;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        grp_cnt_reg <= u8d_pkg::GRP_CNT_W'(u8d_pkg::GRP_DEPTH))
        else $error("group queue count out of range");

    a_eot_results: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_eot_reg) |-> (step.nres != 3'd0))
        else $error("end of text gave no result");

    a_eot_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_eot_reg) |=> (held_cnt_reg == 2'd0))
        else $error("bytes held after end of text");

    a_grp_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((cur_grp.nres != 3'd0) && ({1'b0, idx_reg} < cur_grp.nres)))
        else $error("result index outside its group");

    a_hold_only_partial: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && (step.nres == 3'd0)) |=> (held_cnt_reg != 2'd0))
        else $error("byte consumed without result or held bytes");

endmodule
